[hdl/mtg_pkg.sv]
// Shared types, constants and word functions for the Mersenne twister generator.
package mtg_pkg;

  localparam int unsigned WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  // Twist and tempering constants.
  localparam word_t TWIST_MATRIX = 32'h9908_b0df;
  localparam word_t HIGH_BIT     = 32'h8000_0000;
  localparam word_t LOW_BITS     = 32'h7fff_ffff;
  localparam word_t TEMPER_B     = 32'h9d2c_5680;
  localparam word_t TEMPER_C     = 32'hefc6_0000;

  // Seeding recurrence multiplier and the seed in force after reset.
  localparam word_t SEED_MULT  = 32'd69069;
  localparam word_t SEED_RESET = 32'd4357;

  // One twist: upper bit of the current word, lower bits of the next word,
  // folded into the word at the tap position.
  function automatic word_t twist(input word_t cur, input word_t nxt, input word_t tap);
    word_t y;
    y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    return tap ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
  endfunction

  // Output tempering; only shifts, masks and XORs.
  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

[hdl/mtg_draw_if.sv]
// Request channel: valid/ready handshake carrying the draw bit.
interface mtg_draw_if;
  logic valid;
  logic ready;
  logic draw;

  modport source (output valid, output draw, input ready);
  modport sink (input valid, input draw, output ready);
endinterface

[hdl/mtg_word_if.sv]
// Result channel: valid/ready handshake carrying one tempered word.
interface mtg_word_if;
  logic           valid;
  logic           ready;
  mtg_pkg::word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

[hdl/mtg_state_ram.sv]
// State word memory: one write port and two registered read ports.
module mtg_state_ram #(
  parameter int unsigned DEPTH = 624,
  parameter int unsigned AW    = 10
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  mtg_pkg::word_t wr_data,
  input  logic [AW-1:0]  rd_a_addr,
  output mtg_pkg::word_t rd_a_data,
  input  logic [AW-1:0]  rd_b_addr,
  output mtg_pkg::word_t rd_b_data
);

  mtg_pkg::word_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two read ports, each registered.
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

[hdl/mersenne_twister_generator.sv]
// Top level of the MT19937 random word generator with memory-held state.
//
// Usage: each beat on in_if with draw high returns one tempered 32-bit word
// on out_if; a beat with draw low is taken and returns nothing. With the
// receiver ready, the result is valid on out_if in the cycle after the
// request beat, and the block takes one request and delivers one word every
// cycle. The rate is set by the state memory: each twist reads the next word
// and the tap word through its two read ports while the twisted word is
// written back through the write port; the reads for the following draw are
// issued in the same cycle, and the current word's upper bit is carried over
// from the previous read of the next word.
// Reset, and every write on cfg_we, reloads the 624-word state from the seed
// by the multiply recurrence, one word per cycle, followed by a priming
// state; in_if.ready stays low throughout. After reset the seed is 4357.
// When the receiver stalls, a second result is caught in a skid register and
// the request side is held off only while that register is full.
module mersenne_twister_generator #(
  parameter int unsigned STATE_DEPTH = 624,
  parameter int unsigned TAP_OFFSET  = 397
) (
  input  logic            clk,
  input  logic            rst_n,
  mtg_draw_if.sink        in_if,
  mtg_word_if.source      out_if,
  input  logic            cfg_we,
  input  mtg_pkg::word_t  cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(STATE_DEPTH);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W:0]   idx_sum_t;

  localparam idx_t     LAST_IDX  = idx_t'(STATE_DEPTH - 1);
  localparam idx_sum_t DEPTH_SUM = idx_sum_t'(STATE_DEPTH);
  localparam idx_sum_t TAP_SUM   = idx_sum_t'(TAP_OFFSET);

  typedef enum logic [1:0] {
    ST_FILL,
    ST_PRIME,
    ST_RUN
  } state_t;

  function automatic idx_t idx_inc(input idx_t i);
    return (i == LAST_IDX) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t idx_tap(input idx_t i);
    idx_sum_t s;
    s = {1'b0, i} + TAP_SUM;
    if (s >= DEPTH_SUM) begin
      s = s - DEPTH_SUM;
    end
    return s[IDX_W-1:0];
  endfunction

  // Registers and their next values.
  state_t         state_r, state_nxt;
  idx_t           idx_r, idx_nxt;
  idx_t           fill_idx_r, fill_idx_nxt;
  mtg_pkg::word_t fill_val_r, fill_val_nxt;
  mtg_pkg::word_t cur_top_r, cur_top_nxt;
  logic           out_valid_r, out_valid_nxt;
  mtg_pkg::word_t out_word_r, out_word_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  mtg_pkg::word_t skid_word_r, skid_word_nxt;

  // Memory ports.
  logic           wr_en;
  idx_t           wr_addr;
  mtg_pkg::word_t wr_data;
  idx_t           rd_nxt_addr;
  idx_t           rd_tap_addr;
  mtg_pkg::word_t rd_nxt_data;
  mtg_pkg::word_t rd_tap_data;

  logic           in_ready;
  logic           accept;
  logic           step;
  logic           pop;
  mtg_pkg::word_t twist_word;
  mtg_pkg::word_t result_word;

  mtg_state_ram #(
    .DEPTH (STATE_DEPTH),
    .AW    (IDX_W)
  ) u_state_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_nxt_addr),
    .rd_a_data (rd_nxt_data),
    .rd_b_addr (rd_tap_addr),
    .rd_b_data (rd_tap_data)
  );

  // Handshake decode.
  assign in_ready     = (state_r == ST_RUN) && !skid_valid_r;
  assign accept       = in_if.valid && in_ready;
  assign step         = accept && in_if.draw;
  assign pop          = out_valid_r && out_if.ready;
  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid_r;
  assign out_if.word  = out_word_r;

  // Twist of the current word from the prefetched next and tap words.
  assign twist_word  = mtg_pkg::twist(cur_top_r, rd_nxt_data, rd_tap_data);
  assign result_word = mtg_pkg::temper(twist_word);

  // Read addresses always follow the index of the upcoming draw.
  assign rd_nxt_addr = idx_inc(idx_nxt);
  assign rd_tap_addr = idx_tap(idx_nxt);

  // Write port: seeding sweep or twist write-back.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = twist_word;
    if (state_r == ST_FILL) begin
      wr_en   = 1'b1;
      wr_addr = fill_idx_r;
      wr_data = fill_val_r;
    end else if (step) begin
      wr_en = 1'b1;
    end
  end

  // Sequencer, index and seeding recurrence.
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    fill_idx_nxt = fill_idx_r;
    fill_val_nxt = fill_val_r;
    cur_top_nxt  = cur_top_r;
    if (cfg_we) begin
      state_nxt    = ST_FILL;
      idx_nxt      = '0;
      fill_idx_nxt = '0;
      fill_val_nxt = cfg_wdata;
      cur_top_nxt  = cfg_wdata & mtg_pkg::HIGH_BIT;
    end else begin
      case (state_r)
        ST_FILL: begin
          fill_idx_nxt = idx_inc(fill_idx_r);
          fill_val_nxt = mtg_pkg::word_t'(fill_val_r * mtg_pkg::SEED_MULT);
          if (fill_idx_r == LAST_IDX) begin
            state_nxt = ST_PRIME;
          end
        end
        ST_PRIME: begin
          state_nxt = ST_RUN;
        end
        ST_RUN: begin
          if (step) begin
            idx_nxt     = idx_inc(idx_r);
            cur_top_nxt = rd_nxt_data & mtg_pkg::HIGH_BIT;
          end
        end
        default: begin
          state_nxt = ST_FILL;
        end
      endcase
    end
  end

  // Output register with a skid stage behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    skid_valid_nxt = skid_valid_r;
    skid_word_nxt  = skid_word_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_word_nxt   = skid_word_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (step) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = result_word;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_word_nxt  = result_word;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      idx_r        <= '0;
      fill_idx_r   <= '0;
      fill_val_r   <= mtg_pkg::SEED_RESET;
      cur_top_r    <= mtg_pkg::SEED_RESET & mtg_pkg::HIGH_BIT;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      fill_idx_r   <= fill_idx_nxt;
      fill_val_r   <= fill_val_nxt;
      cur_top_r    <= cur_top_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  // A full skid register always sits behind a full output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // A twist write-back never hits a word being read for the next draw.
  assert property (@(posedge clk) disable iff (!rst_n)
    step |-> (wr_addr != rd_nxt_addr) && (wr_addr != rd_tap_addr))
    else $error("twist write collides with a prefetch read");

  // Each draw advances the index by one, wrapping at the end of the state.
  assert property (@(posedge clk) disable iff (!rst_n)
    step && !cfg_we |=> idx_r == idx_inc($past(idx_r)))
    else $error("index did not advance after a draw");

  // A seed write restarts the seeding sweep from the first word.
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (state_r == ST_FILL) && (fill_idx_r == '0) && (idx_r == '0))
    else $error("seed write did not restart the seeding sweep");

endmodule
